// File: hdl/ncs_pkg.sv
// Shared types, constants and saturating Q32.32 helpers for the spline block.
// No dependencies; every other file imports this package.
package ncs_pkg;

    localparam int IDX_W = 6;            // knot index carried between front and back
    localparam int QUEUE_DEPTH = 4;      // entries between front and back

    localparam logic signed [63:0] Q_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] Q_MIN   = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] Q_THREE = 64'sh0000_0003_0000_0000;

    // One knot request
    typedef struct packed {
        logic signed [31:0] knot_x;
        logic signed [31:0] knot_y;
        logic               final_knot;
    } t_knot;

    // One result request
    typedef struct packed {
        logic [4:0]         interval_index;
        logic signed [63:0] coef_a;
        logic signed [63:0] coef_b;
        logic signed [63:0] coef_c;
        logic signed [63:0] coef_d;
        logic               run_end;
        logic               fault;
    } t_result;

    // Classified knot handed from front to back
    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic               store;
        logic               has_prev;
        logic               final_knot;
        logic               fault;
        logic signed [31:0] y;
        logic signed [32:0] h;
        logic signed [32:0] dy;
    } t_item;

    typedef enum logic {OP_MUL, OP_DIV} t_op;

    typedef struct packed {
        logic               start;
        t_op                op;
        logic signed [63:0] a;
        logic signed [63:0] b;
    } t_arith_req;

    typedef struct packed {
        logic               done;
        logic signed [63:0] res;
    } t_arith_rsp;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
        return s[63:0];
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Signed result from sign, overflow flag and magnitude, saturated
    function automatic logic signed [63:0] from_mag(input logic neg, input logic ovf,
                                                    input logic [63:0] m);
        if (neg) begin
            if (ovf || m[63]) return Q_MIN;
            return -$signed(m);
        end
        if (ovf || m[63]) return Q_MAX;
        return $signed(m);
    endfunction

endpackage

// File: hdl/ncs_front.sv
// Front end: accepts knots, counts them, flags overflow and non-increasing x.
// Depends on ncs_pkg; feeds ncs_queue.
module ncs_front import ncs_pkg::*; #(
    parameter int MAX_KNOTS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_knot i_knot,
    input  logic  i_q_full,
    output logic  o_q_push,
    output t_item o_item
);
    localparam int CW = $clog2(MAX_KNOTS + 1);

    logic [CW-1:0]      r_count;
    logic               r_ovf;
    logic               r_bad;
    logic signed [31:0] r_xprev;
    logic signed [31:0] r_yprev;

    logic signed [32:0] w_h;
    logic               w_stored, w_has_prev, w_bad_now, w_accept;

    // Classify the incoming knot against the previous stored one
    always_comb begin
        w_h        = {i_knot.knot_x[31], i_knot.knot_x} - {r_xprev[31], r_xprev};
        w_stored   = r_count < CW'(MAX_KNOTS);
        w_has_prev = r_count != '0;
        w_bad_now  = w_stored && w_has_prev && (w_h[32] || w_h == '0);
        w_accept   = i_push && !i_q_full;
    end

    assign o_q_push = w_accept;

    always_comb begin
        o_item.idx        = IDX_W'(r_count);
        o_item.store      = w_stored;
        o_item.has_prev   = w_has_prev;
        o_item.final_knot = i_knot.final_knot;
        o_item.fault      = r_ovf || !w_stored || !w_has_prev || r_bad || w_bad_now;
        o_item.y          = i_knot.knot_y;
        o_item.h          = w_h;
        o_item.dy         = {i_knot.knot_y[31], i_knot.knot_y} - {r_yprev[31], r_yprev};
    end

    // Run bookkeeping; a marked knot empties the run
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_bad   <= 1'b0;
        end else if (w_accept) begin
            if (i_knot.final_knot) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                r_bad   <= 1'b0;
            end else if (w_stored) begin
                r_count <= r_count + 1'b1;
                r_bad   <= r_bad || w_bad_now;
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_stored) begin
            r_xprev <= i_knot.knot_x;
            r_yprev <= i_knot.knot_y;
        end
    end

endmodule

// File: hdl/ncs_queue.sv
// Short request queue between the front end and the solver.
// Depends on ncs_pkg.
module ncs_queue import ncs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);
    localparam int PW = $clog2(QUEUE_DEPTH);

    t_item         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [PW:0]   r_fill;

    assign o_full  = r_fill == (PW+1)'(QUEUE_DEPTH);
    assign o_empty = r_fill == '0;
    assign o_item  = r_mem[r_rptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) r_wptr <= (r_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            if (i_pop)  r_rptr <= (r_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            if (i_push && !i_pop) r_fill <= r_fill + 1'b1;
            else if (!i_push && i_pop) r_fill <= r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_item;
    end

endmodule

// File: hdl/ncs_arith.sv
// Shared multi-cycle Q32.32 unit: multiply from four 32x32 partial products,
// restoring divide two quotient bits per cycle. Depends on ncs_pkg.
module ncs_arith import ncs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_arith_req i_req,
    output t_arith_rsp o_rsp
);
    localparam int DIV_BITS = 2;
    localparam int DIV_CYC  = 96 / DIV_BITS;

    typedef enum logic [1:0] {A_IDLE, A_DIV, A_MUL, A_FIN} t_state;

    t_state             r_state;
    t_op                r_op;
    logic               r_neg;
    logic [63:0]        r_a_mag, r_b_mag;
    logic [95:0]        r_num, r_q;
    logic [64:0]        r_rem;
    logic [127:0]       r_acc;
    logic [63:0]        r_prod;
    logic [1:0]         r_psel;
    logic [5:0]         r_cnt;
    logic               r_done;
    logic signed [63:0] r_res;

    logic [95:0]  w_num, w_q;
    logic [64:0]  w_rem;
    logic [31:0]  w_pa, w_pb;
    logic [127:0] w_term;

    // Divide step: DIV_BITS shift-compare-subtract rounds
    always_comb begin
        w_rem = r_rem;
        w_num = r_num;
        w_q   = r_q;
        for (int k = 0; k < DIV_BITS; k++) begin
            w_rem = {w_rem[63:0], w_num[95]};
            w_num = w_num << 1;
            w_q   = w_q << 1;
            if (w_rem >= {1'b0, r_b_mag}) begin
                w_rem = w_rem - {1'b0, r_b_mag};
                w_q[0] = 1'b1;
            end
        end
    end

    // Partial product select and its alignment in the accumulator
    always_comb begin
        w_pa = r_cnt[1] ? r_a_mag[63:32] : r_a_mag[31:0];
        w_pb = r_cnt[0] ? r_b_mag[63:32] : r_b_mag[31:0];
        if (r_psel == 2'd0)      w_term = {64'd0, r_prod};
        else if (r_psel == 2'd3) w_term = {r_prod, 64'd0};
        else                     w_term = {32'd0, r_prod, 32'd0};
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        r_op    <= i_req.op;
                        r_neg   <= i_req.a[63] ^ i_req.b[63];
                        r_a_mag <= mag(i_req.a);
                        r_b_mag <= mag(i_req.b);
                        r_num   <= {mag(i_req.a), 32'd0};
                        r_rem   <= '0;
                        r_q     <= '0;
                        r_acc   <= '0;
                        if (i_req.op == OP_DIV) begin
                            r_cnt   <= 6'(DIV_CYC - 1);
                            r_state <= (i_req.b == '0) ? A_FIN : A_DIV;
                        end else begin
                            r_cnt   <= '0;
                            r_state <= A_MUL;
                        end
                    end
                end
                A_DIV: begin
                    r_rem <= w_rem;
                    r_num <= w_num;
                    r_q   <= w_q;
                    if (r_cnt == '0) r_state <= A_FIN;
                    else r_cnt <= r_cnt - 1'b1;
                end
                A_MUL: begin
                    if (r_cnt < 6'd4) begin
                        r_prod <= w_pa * w_pb;
                        r_psel <= r_cnt[1:0];
                    end
                    if (r_cnt != '0) r_acc <= r_acc + w_term;
                    if (r_cnt == 6'd4) r_state <= A_FIN;
                    else r_cnt <= r_cnt + 1'b1;
                end
                A_FIN: begin
                    r_res   <= (r_op == OP_MUL)
                             ? from_mag(r_neg, |r_acc[127:96], r_acc[95:32])
                             : from_mag(r_neg, |r_q[95:64], r_q[63:0]);
                    r_done  <= 1'b1;
                    r_state <= A_IDLE;
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

endmodule

// File: hdl/ncs_back.sv
// Solver: stores knots, runs the tridiagonal sweep and back substitution on
// the shared arith unit, then emits coefficients. Depends on ncs_pkg.
module ncs_back import ncs_pkg::*; #(
    parameter int MAX_KNOTS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_item      i_item,
    input  logic       i_q_empty,
    output logic       o_q_pop,
    output t_arith_req o_req,
    input  t_arith_rsp i_rsp,
    output t_result    o_result,
    output logic       o_empty,
    input  logic       i_pop
);
    localparam int KW = $clog2(MAX_KNOTS);
    localparam int SH = 32 - FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_RD, S_WAIT, S_FLT,
        S_F1, S_F2, S_F3, S_F4, S_F5, S_F6, S_F7, S_F8,
        S_B1, S_B2, S_B3, S_B4, S_B5, S_B6, S_B7,
        S_O1
    } t_state;

    // Stores
    logic signed [31:0] y_mem     [MAX_KNOTS];
    logic signed [63:0] h_mem     [MAX_KNOTS];
    logic signed [63:0] dy_mem    [MAX_KNOTS];
    logic signed [63:0] ratio_mem [MAX_KNOTS];
    logic signed [63:0] sweep_mem [MAX_KNOTS];
    logic signed [63:0] quad_mem  [MAX_KNOTS];
    logic signed [63:0] b_mem     [MAX_KNOTS];
    logic signed [63:0] d_mem     [MAX_KNOTS];

    logic signed [31:0] r_y_rd;
    logic signed [63:0] r_h_rd, r_dy_rd, r_ratio_rd, r_sweep_rd, r_quad_rd, r_b_rd, r_d_rd;

    t_state             r_state, r_ret;
    logic [KW-1:0]      r_addr, r_i, r_n;
    t_arith_req         r_req;
    logic               r_ov;
    t_result            r_out;
    logic signed [63:0] r_h, r_dy, r_hp, r_tprev, r_rp, r_sp, r_l, r_t1;
    logic signed [63:0] r_ratio, r_sweep, r_cn, r_c;

    logic [KW-1:0]      w_ix, w_ixm1;
    logic signed [63:0] w_hq_in, w_dy_in, w_res, w_l, w_s;
    logic               w_take, w_out_free;

    always_comb begin
        w_ix       = i_item.idx[KW-1:0];
        w_ixm1     = w_ix - 1'b1;
        w_hq_in    = {{31{i_item.h[32]}}, i_item.h} << SH;
        w_dy_in    = {{31{i_item.dy[32]}}, i_item.dy} << SH;
        w_res      = i_rsp.res;
        w_l        = sat_sub((r_hp + r_h) <<< 1, w_res);
        w_s        = sat_add(r_cn, sat_add(r_c, r_c));
        w_take     = (r_state == S_IDLE) && !i_q_empty;
        w_out_free = !r_ov || i_pop;
    end

    assign o_q_pop  = w_take;
    assign o_req    = r_req;
    assign o_result = r_out;
    assign o_empty  = !r_ov;

    // Store writes, one address per store, and registered reads at r_addr
    always_ff @(posedge i_clk) begin
        if (w_take && i_item.store) begin
            y_mem[w_ix] <= i_item.y;
            if (i_item.has_prev) begin
                h_mem[w_ixm1]  <= w_hq_in;
                dy_mem[w_ixm1] <= w_dy_in;
            end
        end
        if (r_state == S_F2) begin
            ratio_mem[0] <= '0;
            sweep_mem[0] <= '0;
        end
        if (r_state == S_F8) begin
            ratio_mem[r_i] <= r_ratio;
            sweep_mem[r_i] <= w_res;
        end
        if (r_state == S_B7) begin
            quad_mem[r_i] <= r_c;
            b_mem[r_i]    <= r_t1;
            d_mem[r_i]    <= w_res;
        end
        r_y_rd     <= y_mem[r_addr];
        r_h_rd     <= h_mem[r_addr];
        r_dy_rd    <= dy_mem[r_addr];
        r_ratio_rd <= ratio_mem[r_addr];
        r_sweep_rd <= sweep_mem[r_addr];
        r_quad_rd  <= quad_mem[r_addr];
        r_b_rd     <= b_mem[r_addr];
        r_d_rd     <= d_mem[r_addr];
    end

    // Solver sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ret       <= S_IDLE;
            r_req.start <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_req.start <= 1'b0;
            if (i_pop && r_ov) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_take && i_item.final_knot) begin
                        if (i_item.fault) begin
                            r_state <= S_FLT;
                        end else begin
                            r_n     <= w_ix;
                            r_addr  <= '0;
                            r_ret   <= S_F1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: r_state <= r_ret;
                S_WAIT: begin
                    if (i_rsp.done) r_state <= r_ret;
                end
                S_FLT: begin
                    if (w_out_free) begin
                        r_ov    <= 1'b1;
                        r_out   <= '{interval_index: '0, coef_a: '0, coef_b: '0,
                                     coef_c: '0, coef_d: '0, run_end: 1'b1, fault: 1'b1};
                        r_state <= S_IDLE;
                    end
                end
                // forward sweep
                S_F1: begin
                    r_h     <= r_h_rd;
                    r_dy    <= r_dy_rd;
                    r_req   <= '{start: 1'b1, op: OP_DIV, a: (r_dy_rd <<< 1) + r_dy_rd,
                                 b: r_h_rd};
                    r_ret   <= S_F2;
                    r_state <= S_WAIT;
                end
                S_F2: begin
                    r_tprev <= w_res;
                    r_hp    <= r_h;
                    r_rp    <= '0;
                    r_sp    <= '0;
                    r_state <= S_RD;
                    if (r_n == KW'(1)) begin
                        r_cn   <= '0;
                        r_i    <= '0;
                        r_addr <= '0;
                        r_ret  <= S_B1;
                    end else begin
                        r_i    <= KW'(1);
                        r_addr <= KW'(1);
                        r_ret  <= S_F3;
                    end
                end
                S_F3: begin
                    r_h     <= r_h_rd;
                    r_dy    <= r_dy_rd;
                    r_req   <= '{start: 1'b1, op: OP_DIV, a: (r_dy_rd <<< 1) + r_dy_rd,
                                 b: r_h_rd};
                    r_ret   <= S_F4;
                    r_state <= S_WAIT;
                end
                S_F4: begin
                    r_t1    <= sat_sub(w_res, r_tprev);
                    r_tprev <= w_res;
                    r_req   <= '{start: 1'b1, op: OP_MUL, a: r_hp, b: r_rp};
                    r_ret   <= S_F5;
                    r_state <= S_WAIT;
                end
                S_F5: begin
                    r_l     <= w_l;
                    r_req   <= '{start: 1'b1, op: OP_DIV, a: r_h, b: w_l};
                    r_ret   <= S_F6;
                    r_state <= S_WAIT;
                end
                S_F6: begin
                    r_ratio <= w_res;
                    r_req   <= '{start: 1'b1, op: OP_MUL, a: r_hp, b: r_sp};
                    r_ret   <= S_F7;
                    r_state <= S_WAIT;
                end
                S_F7: begin
                    r_req   <= '{start: 1'b1, op: OP_DIV, a: sat_sub(r_t1, w_res), b: r_l};
                    r_ret   <= S_F8;
                    r_state <= S_WAIT;
                end
                S_F8: begin
                    r_rp    <= r_ratio;
                    r_sp    <= w_res;
                    r_hp    <= r_h;
                    r_state <= S_RD;
                    if (r_i == r_n - 1'b1) begin
                        r_cn   <= '0;
                        r_addr <= r_i;
                        r_ret  <= S_B1;
                    end else begin
                        r_i    <= r_i + 1'b1;
                        r_addr <= r_i + 1'b1;
                        r_ret  <= S_F3;
                    end
                end
                // back substitution, last interval first
                S_B1: begin
                    r_ratio <= r_ratio_rd;
                    r_sweep <= r_sweep_rd;
                    r_h     <= r_h_rd;
                    r_dy    <= r_dy_rd;
                    r_req   <= '{start: 1'b1, op: OP_MUL, a: r_ratio_rd, b: r_cn};
                    r_ret   <= S_B2;
                    r_state <= S_WAIT;
                end
                S_B2: begin
                    r_c     <= sat_sub(r_sweep, w_res);
                    r_state <= S_B3;
                end
                S_B3: begin
                    r_req   <= '{start: 1'b1, op: OP_MUL, a: r_h, b: w_s};
                    r_ret   <= S_B4;
                    r_state <= S_WAIT;
                end
                S_B4: begin
                    r_req   <= '{start: 1'b1, op: OP_DIV, a: w_res, b: Q_THREE};
                    r_ret   <= S_B5;
                    r_state <= S_WAIT;
                end
                S_B5: begin
                    r_t1    <= w_res;
                    r_req   <= '{start: 1'b1, op: OP_DIV, a: r_dy, b: r_h};
                    r_ret   <= S_B6;
                    r_state <= S_WAIT;
                end
                S_B6: begin
                    r_t1    <= sat_sub(w_res, r_t1);
                    r_req   <= '{start: 1'b1, op: OP_DIV, a: sat_sub(r_cn, r_c),
                                 b: (r_h <<< 1) + r_h};
                    r_ret   <= S_B7;
                    r_state <= S_WAIT;
                end
                S_B7: begin
                    r_cn    <= r_c;
                    r_state <= S_RD;
                    if (r_i == '0) begin
                        r_addr <= '0;
                        r_ret  <= S_O1;
                    end else begin
                        r_i    <= r_i - 1'b1;
                        r_addr <= r_i - 1'b1;
                        r_ret  <= S_B1;
                    end
                end
                // emit intervals in order
                S_O1: begin
                    if (w_out_free) begin
                        r_ov  <= 1'b1;
                        r_out <= '{interval_index: 5'(r_i),
                                   coef_a: {{32{r_y_rd[31]}}, r_y_rd} << SH,
                                   coef_b: r_b_rd, coef_c: r_quad_rd, coef_d: r_d_rd,
                                   run_end: r_i == r_n - 1'b1, fault: 1'b0};
                        if (r_i == r_n - 1'b1) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_addr  <= r_i + 1'b1;
                            r_ret   <= S_O1;
                            r_state <= S_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: hdl/natural_cubic_spline_coefficients.sv
// Top level of the natural cubic spline coefficient generator.
// Depends on ncs_pkg, ncs_front, ncs_queue, ncs_arith, ncs_back.
//
//  channel   | handshake           | payload
//  ----------+---------------------+-------------------------------
//  knots in  | push / full         | i_knot   (t_knot)
//  results   | empty / pop         | o_result (t_result)
//
// A knot is taken whenever push is high and full is low; up to four wait in the
// queue while a run solves. A marked knot with n intervals is solved on the
// shared arith unit: each interval needs six divides (two quotient bits per
// cycle) and four multiplies; the results are then emitted in order.
// Reset is synchronous, active low; stores need no clearing.
// A stalled result holds in the output register; the solver waits behind it.
module natural_cubic_spline_coefficients import ncs_pkg::*; #(
    parameter int MAX_KNOTS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    push,
    output logic    full,
    input  t_knot   i_knot,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);
    t_item      q_in_item, q_out_item;
    logic       q_push, q_pop, q_full, q_empty;
    t_arith_req arith_req;
    t_arith_rsp arith_rsp;

    assign full = q_full;

    ncs_front #(.MAX_KNOTS(MAX_KNOTS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_knot   (i_knot),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_item   (q_in_item)
    );

    ncs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_out_item),
        .o_empty (q_empty)
    );

    ncs_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (arith_req),
        .o_rsp   (arith_rsp)
    );

    ncs_back #(.MAX_KNOTS(MAX_KNOTS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (q_out_item),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_req     (arith_req),
        .i_rsp     (arith_rsp),
        .o_result  (o_result),
        .o_empty   (empty),
        .i_pop     (pop)
    );

    // The solver never takes from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty) else $error("queue popped while empty");

    // A fault result ends the run and carries zero coefficients
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.fault) |-> (o_result.run_end && o_result.coef_a == '0 &&
        o_result.coef_b == '0 && o_result.coef_c == '0 && o_result.coef_d == '0))
        else $error("fault result with nonzero fields");

    // Queue comes out of reset with room, and no result is held
    a_reset_room: assert property (@(posedge i_clk)
        !i_rst_n |=> (!full && empty)) else $error("not clear after reset");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for natural_cubic_spline_coefficients.
// Depends on ncs_pkg and the block's RTL; knots are driven, and each result is
// checked against a scoreboard that solves the spline in Q32.32 on its own.

// Expected results come from a local spline solver fed with every accepted knot
class spline_scoreboard;
    localparam int KNOT_CAP = 32;
    localparam int IN_SHIFT = 16;                // Q16.16 to Q32.32

    logic signed [63:0] knot_xs [KNOT_CAP];
    logic signed [63:0] knot_ys [KNOT_CAP];
    int                 stored;
    bit                 dropped;
    ncs_pkg::t_result   coef_fifo [$];
    int                 errors;
    int                 seen_results;
    int                 seen_faults;

    function new();
        stored = 0;
        dropped = 0;
        errors = 0;
        seen_results = 0;
        seen_faults = 0;
    endfunction

    function int pending();
        return coef_fifo.size();
    endfunction

    function logic [63:0] umag(logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // Sign + magnitude back to signed, clamped to the 64-bit range
    function logic signed [63:0] clamp_mag(bit neg, bit ovf, logic [63:0] m);
        if (neg) begin
            if (ovf || m[63]) return ncs_pkg::Q_MIN;
            return -$signed(m);
        end
        if (ovf || m[63]) return ncs_pkg::Q_MAX;
        return $signed(m);
    endfunction

    function logic signed [63:0] q_add(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? ncs_pkg::Q_MIN : ncs_pkg::Q_MAX;
        return s[63:0];
    endfunction

    function logic signed [63:0] q_sub(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? ncs_pkg::Q_MIN : ncs_pkg::Q_MAX;
        return s[63:0];
    endfunction

    // Exact product of magnitudes, truncated to Q32.32
    function logic signed [63:0] q_mul(logic signed [63:0] a, logic signed [63:0] b);
        logic [127:0] p;
        p = 128'(umag(a)) * 128'(umag(b));
        return clamp_mag(a[63] ^ b[63], p[127:96] != 0, p[95:32]);
    endfunction

    // Exact quotient truncated toward zero; divide by zero yields zero
    function logic signed [63:0] q_div(logic signed [63:0] a, logic signed [63:0] b);
        logic [127:0] num;
        logic [127:0] q;
        if (b == 0) return 0;
        num = {32'b0, umag(a), 32'b0};
        q = num / 128'(umag(b));
        return clamp_mag(a[63] ^ b[63], q[127:64] != 0, q[63:0]);
    endfunction

    function void add_result(int j, logic signed [63:0] a, logic signed [63:0] b,
                             logic signed [63:0] c, logic signed [63:0] d,
                             bit last, bit bad);
        ncs_pkg::t_result r;
        r.interval_index = 5'(j);
        r.coef_a = a;
        r.coef_b = b;
        r.coef_c = c;
        r.coef_d = d;
        r.run_end = last;
        r.fault = bad;
        coef_fifo.push_back(r);
    endfunction

    // Tridiagonal solve with zero curvature at both ends
    function void solve_run();
        logic signed [63:0] hq [KNOT_CAP];
        logic signed [63:0] dq [KNOT_CAP];
        logic signed [63:0] ratio [KNOT_CAP];
        logic signed [63:0] sweep [KNOT_CAP];
        logic signed [63:0] quad [KNOT_CAP+1];
        logic signed [63:0] lin [KNOT_CAP];
        logic signed [63:0] cub [KNOT_CAP];
        logic signed [63:0] alp, piv, s;
        bit bad;
        int n;
        bad = dropped || stored < 2;
        n = stored - 1;
        for (int i = 0; !bad && i < n; i++) begin
            if (knot_xs[i+1] - knot_xs[i] <= 0) bad = 1;
        end
        stored = 0;
        dropped = 0;
        if (bad) begin
            add_result(0, 0, 0, 0, 0, 1, 1);
            return;
        end
        for (int i = 0; i < n; i++) begin
            hq[i] = (knot_xs[i+1] - knot_xs[i]) <<< IN_SHIFT;
            dq[i] = (knot_ys[i+1] - knot_ys[i]) <<< IN_SHIFT;
        end
        ratio[0] = 0;
        sweep[0] = 0;
        for (int i = 1; i < n; i++) begin
            alp = q_sub(q_div(3 * dq[i], hq[i]), q_div(3 * dq[i-1], hq[i-1]));
            piv = q_sub(2 * (hq[i-1] + hq[i]), q_mul(hq[i-1], ratio[i-1]));
            ratio[i] = q_div(hq[i], piv);
            sweep[i] = q_div(q_sub(alp, q_mul(hq[i-1], sweep[i-1])), piv);
        end
        quad[n] = 0;
        for (int j = n - 1; j >= 0; j--) begin
            quad[j] = q_sub(sweep[j], q_mul(ratio[j], quad[j+1]));
            s = q_add(quad[j+1], q_add(quad[j], quad[j]));
            lin[j] = q_sub(q_div(dq[j], hq[j]), q_div(q_mul(hq[j], s), ncs_pkg::Q_THREE));
            cub[j] = q_div(q_sub(quad[j+1], quad[j]), 3 * hq[j]);
        end
        for (int i = 0; i < n; i++)
            add_result(i, knot_ys[i] <<< IN_SHIFT, lin[i], quad[i], cub[i], i + 1 == n, 0);
    endfunction

    // Accepted knot request: store it, solve on the marked one
    function void note_knot(ncs_pkg::t_knot k);
        if (stored < KNOT_CAP) begin
            knot_xs[stored] = 64'(k.knot_x);
            knot_ys[stored] = 64'(k.knot_y);
            stored++;
        end else begin
            dropped = 1;
        end
        if (k.final_knot) solve_run();
    endfunction

    function void cmp_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, got_v);
            errors++;
        end
    endfunction

    // Accepted result request against the oldest expectation
    function void check_result(ncs_pkg::t_result r);
        ncs_pkg::t_result e;
        seen_results++;
        if (r.fault) seen_faults++;
        if (coef_fifo.size() == 0) begin
            $error("unexpected result: interval %0d", r.interval_index);
            errors++;
            return;
        end
        e = coef_fifo.pop_front();
        cmp_field("interval_index", 64'(e.interval_index), 64'(r.interval_index));
        cmp_field("coef_a", e.coef_a, r.coef_a);
        cmp_field("coef_b", e.coef_b, r.coef_b);
        cmp_field("coef_c", e.coef_c, r.coef_c);
        cmp_field("coef_d", e.coef_d, r.coef_d);
        cmp_field("run_end", 64'(e.run_end), 64'(r.run_end));
        cmp_field("fault", 64'(e.fault), 64'(r.fault));
    endfunction
endclass

module testbench;
    import ncs_pkg::*;

    localparam int KNOT_GOAL = 220;
    localparam int STALL_LIMIT = 100000;
    localparam int DRAIN_CYCLES = 400;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    push = 1'b0;
    logic    pop = 1'b0;
    t_knot   i_knot = '0;
    logic    full;
    logic    empty;
    t_result o_result;

    spline_scoreboard sb = new();
    int  knots_sent = 0;
    int  quiet_cycles = 0;
    bit  send_gaps = 1;
    bit  take_gaps = 1;

    natural_cubic_spline_coefficients uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_knot   (i_knot),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Monitor both handshakes on pre-edge values; watchdog on idle cycles
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) sb.note_knot(i_knot);
            if (pop && !empty) sb.check_result(o_result);
            if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog expired with %0d results pending", sb.pending());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // One knot request; push stays high across back-to-back requests
    task automatic send_knot(logic signed [31:0] x, logic signed [31:0] y, bit last);
        int gap;
        gap = send_gaps ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_knot <= '{knot_x: x, knot_y: y, final_knot: last};
        do @(posedge i_clk); while (full);
        knots_sent++;
    endtask

    // Random valid run: strictly increasing x, spacing scaled by a random shift
    task automatic send_run(int cnt, bit wide_y);
        longint span, x;
        int sh;
        sh = $urandom_range(0, 26);
        span = longint'(cnt) * (longint'(1) << sh);
        x = -longint'(2147483648) + ($urandom() % (longint'(4294967296) - span));
        for (int i = 0; i < cnt; i++) begin
            send_knot(32'(x), wide_y ? 32'($urandom()) : 32'($urandom_range(0, 8191)) - 4096,
                      i == cnt - 1);
            x += 1 + (longint'($urandom()) % (longint'(1) << sh));
        end
    endtask

    // Result side: random stalls, pop held high while waiting
    initial begin
        int stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = take_gaps ? $urandom_range(0, 14) : 0;
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    initial begin
        int kind, cnt;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: lone marked knot (too few knots)
        send_knot(32'sd0, 32'sd0, 1);
        // extremes of x and y over a two-knot run
        send_knot(32'sh8000_0000, 32'sh7FFF_FFFF, 0);
        send_knot(32'sh7FFF_FFFF, 32'sh8000_0000, 1);
        // repeated x
        send_knot(32'sd5, 32'sd1, 0);
        send_knot(32'sd5, 32'sd2, 0);
        send_knot(32'sd9, 32'sd3, 1);
        // decreasing x
        send_knot(32'sd10, 32'sd7, 0);
        send_knot(32'sd3, 32'sd7, 1);
        // ordinary smooth run
        send_knot(32'sh0000_0000, 32'sh0000_0000, 0);
        send_knot(32'sh0001_0000, 32'sh0001_0000, 0);
        send_knot(32'sh0002_0000, 32'sh0000_8000, 0);
        send_knot(32'sh0003_8000, 32'shFFFF_0000, 1);
        // tiny widths with extreme y: drives the arithmetic into saturation
        send_knot(32'sd100, 32'sh7FFF_FFFF, 0);
        send_knot(32'sd101, 32'sh8000_0000, 0);
        send_knot(32'sd102, 32'sh7FFF_FFFF, 1);
        // store overflow
        for (int i = 0; i < 34; i++)
            send_knot(32'(i * 16), 32'(i), i == 33);

        // Random runs until the knot budget is spent
        while (knots_sent < KNOT_GOAL) begin
            send_gaps = $urandom_range(0, 3) != 0;
            take_gaps = $urandom_range(0, 3) != 0;
            kind = $urandom_range(0, 99);
            if (kind < 5) begin
                cnt = $urandom_range(33, 36);
                for (int i = 0; i < cnt; i++)
                    send_knot(32'($urandom()), 32'($urandom()), i == cnt - 1);
            end else if (kind < 15) begin
                cnt = $urandom_range(2, 5);
                for (int i = 0; i < cnt; i++)
                    send_knot(32'($urandom()), 32'($urandom()), i == cnt - 1);
            end else if (kind < 20) begin
                send_knot(32'($urandom()), 32'($urandom()), 1);
            end else begin
                cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 32)
                                                  : $urandom_range(2, 6);
                send_run(cnt, $urandom_range(0, 1));
            end
        end
        push <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d results never arrived", sb.pending());
            sb.errors++;
        end
        $display("sent %0d knots; checked %0d results, %0d of them fault results",
                 knots_sent, sb.seen_results, sb.seen_faults);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
